[src/wsfe_pkg.sv]
// ----------------------------------------------------------------------------
// wsfe_pkg
// Shared types, codes and helpers for the WebSocket frame encoder.
// ----------------------------------------------------------------------------
`default_nettype none
package wsfe_pkg;

	localparam int WSFE_QUEUE_DEPTH = 4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_INVALID  = 2'd1;
	localparam logic [1:0] ST_NO_SPACE = 2'd2;
	localparam logic [1:0] ST_NO_FRAME = 2'd3;

	localparam logic       FUNC_START   = 1'b0;
	localparam logic       FUNC_PAYLOAD = 1'b1;

	localparam logic [3:0] OPC_DATA_MAX = 4'd2;
	localparam logic [3:0] OPC_CLOSE    = 4'd8;
	localparam logic [3:0] OPC_PONG     = 4'd10;

	localparam logic [63:0] LEN_CTRL_MAX  = 64'd125;
	localparam logic [6:0]  LEN_CODE_16   = 7'd126;
	localparam logic [6:0]  LEN_CODE_64   = 7'd127;

	typedef enum logic {
		CMD_SINGLE,
		CMD_HEADER
	} cmd_kind_t;

	typedef enum logic [1:0] {
		LEN_SHORT,
		LEN_16,
		LEN_64
	} len_form_t;

	typedef struct packed {
		cmd_kind_t   kind;
		len_form_t   len_form;
		logic [3:0]  hdr_last;
		logic [7:0]  byte0;
		logic [7:0]  byte1;
		logic [63:0] len;
		logic [31:0] key;
		logic        byte_valid;
		logic [1:0]  status;
		logic        done;
	} cmd_t;

	function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0: b = key[31:24];
			2'd1: b = key[23:16];
			2'd2: b = key[15:8];
			default: b = key[7:0];
		endcase
		return b;
	endfunction

	function automatic logic [7:0] len_byte(input logic [63:0] len, input logic [2:0] idx);
		return len[{~idx, 3'b000} +: 8];
	endfunction

endpackage
`default_nettype wire

[src/wsfe_front.sv]
// ----------------------------------------------------------------------------
// wsfe_front
// Accepts items, checks frame requests, tracks the open frame and masks
// payload bytes; hands one command per item to the queue.
// ----------------------------------------------------------------------------
`default_nettype none
module wsfe_front import wsfe_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        accept,
	input  wire logic        func,
	input  wire logic [3:0]  opcode,
	input  wire logic        fin_flag,
	input  wire logic [63:0] payload_length,
	input  wire logic        mask_enable,
	input  wire logic [31:0] mask_key,
	input  wire logic [63:0] out_room,
	input  wire logic [7:0]  data_byte,
	output cmd_t             cmd
);

	logic        frame_open_q;
	logic [63:0] remaining_q;
	logic [31:0] key_q;
	logic        mask_on_q;
	logic [1:0]  phase_q;

	logic        valid_op, control, bad_req, no_space, is_short, is_16;
	logic [3:0]  hdr_len;
	logic [64:0] total;
	logic        last_payload;

	always_comb begin
		valid_op = (opcode <= OPC_DATA_MAX) || (opcode >= OPC_CLOSE && opcode <= OPC_PONG);
		control  = opcode >= OPC_CLOSE && opcode <= OPC_PONG;
		bad_req  = !valid_op || (control && (!fin_flag || payload_length > LEN_CTRL_MAX));
		is_short = payload_length < 64'd126;
		is_16    = !is_short && (payload_length[63:16] == 48'd0);
		hdr_len  = 4'd2 + (is_short ? 4'd0 : (is_16 ? 4'd2 : 4'd8)) + (mask_enable ? 4'd4 : 4'd0);
		total    = {1'b0, payload_length} + {61'd0, hdr_len};
		no_space = total[64] || (out_room < total[63:0]);
		last_payload = remaining_q == 64'd1;

		cmd = '0;
		cmd.kind = CMD_SINGLE;
		cmd.len_form = LEN_SHORT;
		if (func == FUNC_PAYLOAD) begin
			cmd.status = frame_open_q ? ST_OK : ST_NO_FRAME;
			if (frame_open_q) begin
				cmd.byte0      = data_byte ^ (mask_on_q ? key_byte(key_q, phase_q) : 8'd0);
				cmd.byte_valid = 1'b1;
				cmd.done       = last_payload;
			end
		end else if (bad_req) begin
			cmd.status = ST_INVALID;
		end else if (no_space) begin
			cmd.status = ST_NO_SPACE;
		end else begin
			cmd.kind     = CMD_HEADER;
			cmd.status   = ST_OK;
			cmd.hdr_last = hdr_len - 4'd1;
			cmd.byte0    = {fin_flag, 3'b000, opcode};
			cmd.len      = payload_length;
			cmd.key      = mask_key;
			cmd.done     = payload_length == 64'd0;
			if (is_short) begin
				cmd.len_form = LEN_SHORT;
				cmd.byte1    = {mask_enable, payload_length[6:0]};
			end else if (is_16) begin
				cmd.len_form = LEN_16;
				cmd.byte1    = {mask_enable, LEN_CODE_16};
			end else begin
				cmd.len_form = LEN_64;
				cmd.byte1    = {mask_enable, LEN_CODE_64};
			end
			cmd.byte_valid = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q <= 1'b0;
			remaining_q  <= '0;
			key_q        <= '0;
			mask_on_q    <= 1'b0;
			phase_q      <= '0;
		end else if (accept) begin
			if (func == FUNC_PAYLOAD) begin
				if (frame_open_q) begin
					phase_q     <= phase_q + 2'd1;
					remaining_q <= remaining_q - 64'd1;
					if (last_payload)
						frame_open_q <= 1'b0;
				end
			end else if (bad_req || no_space) begin
				frame_open_q <= 1'b0;
				remaining_q  <= '0;
			end else begin
				frame_open_q <= payload_length != 64'd0;
				remaining_q  <= payload_length;
				key_q        <= mask_key;
				mask_on_q    <= mask_enable;
				phase_q      <= '0;
			end
		end
	end

endmodule
`default_nettype wire

[src/wsfe_queue.sv]
// ----------------------------------------------------------------------------
// wsfe_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none
module wsfe_queue import wsfe_pkg::*; #(
	parameter int Depth = WSFE_QUEUE_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	output logic      full,
	input  wire logic pop,
	output logic      head_valid,
	output cmd_t      head_cmd
);

	localparam int PtrW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] Full    = CntW'(Depth);

	cmd_t            entries_q [Depth];
	logic [PtrW-1:0] wr_q, rd_q;
	logic [CntW-1:0] count_q;

	assign full       = count_q == Full;
	assign head_valid = count_q != '0;
	assign head_cmd   = entries_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == LastIdx) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == LastIdx) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

[src/wsfe_back.sv]
// ----------------------------------------------------------------------------
// wsfe_back
// Expands queued commands into result items, one per cycle while the
// output is not stalled, through an output register.
// ----------------------------------------------------------------------------
`default_nettype none
module wsfe_back import wsfe_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  head_valid,
	input  wire cmd_t  head_cmd,
	output logic       pop,
	output logic       out_valid,
	input  wire logic  out_stall,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic [1:0] status,
	output logic       last,
	output logic       frame_done
);

	logic [3:0] idx_q;
	logic       valid_q;
	logic       load, hdr_end;
	logic [3:0] j;
	logic [7:0] hdr_byte;

	assign load    = head_valid && (!valid_q || !out_stall);
	assign hdr_end = idx_q == head_cmd.hdr_last;
	assign pop     = load && (head_cmd.kind == CMD_SINGLE || hdr_end);
	assign out_valid = valid_q;

	always_comb begin
		j = idx_q - 4'd2;
		if (idx_q == 4'd0) begin
			hdr_byte = head_cmd.byte0;
		end else if (idx_q == 4'd1) begin
			hdr_byte = head_cmd.byte1;
		end else begin
			case (head_cmd.len_form)
				LEN_16: begin
					if (j < 4'd2)
						hdr_byte = j[0] ? head_cmd.len[7:0] : head_cmd.len[15:8];
					else
						hdr_byte = key_byte(head_cmd.key, j[1:0] + 2'd2);
				end
				LEN_64: begin
					if (j < 4'd8)
						hdr_byte = len_byte(head_cmd.len, j[2:0]);
					else
						hdr_byte = key_byte(head_cmd.key, j[1:0]);
				end
				default: hdr_byte = key_byte(head_cmd.key, j[1:0]);
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load)
				valid_q <= 1'b1;
			else if (!out_stall)
				valid_q <= 1'b0;
			if (load && head_cmd.kind == CMD_HEADER)
				idx_q <= hdr_end ? 4'd0 : idx_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_valid <= head_cmd.byte_valid;
			status     <= head_cmd.status;
			if (head_cmd.kind == CMD_SINGLE) begin
				out_byte   <= head_cmd.byte0;
				last       <= 1'b1;
				frame_done <= head_cmd.done;
			end else begin
				out_byte   <= hdr_byte;
				last       <= hdr_end;
				frame_done <= hdr_end && head_cmd.done;
			end
		end
	end

endmodule
`default_nettype wire

[src/websocket_frame_encoder_unit.sv]
// ----------------------------------------------------------------------------
// websocket_frame_encoder_unit
// WebSocket base-framing encoder: header burst per accepted start item, one
// byte, masked if enabled, per payload item.
// ----------------------------------------------------------------------------
// Items are taken at one per cycle while the command queue has room. A
// payload item, a rejected start or a stray payload gives one result item;
// an accepted start gives its 2 to 14 header bytes, one per unstalled cycle,
// from the back part's byte counter. Sustained rate is one result per cycle
// while the output is not stalled; input stalls only when QUEUE_DEPTH
// commands wait behind a header burst or a stalled output.
`default_nettype none
module websocket_frame_encoder_unit import wsfe_pkg::*; #(
	parameter int QUEUE_DEPTH = WSFE_QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        func,
	input  wire logic [3:0]  opcode,
	input  wire logic        fin_flag,
	input  wire logic [63:0] payload_length,
	input  wire logic        mask_enable,
	input  wire logic [31:0] mask_key,
	input  wire logic [63:0] out_room,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic             byte_valid,
	output logic [1:0]       status,
	output logic             last,
	output logic             frame_done
);

	logic accept, full, pop, head_valid;
	cmd_t cmd, head_cmd;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	wsfe_front u_front (
		.clk, .arst_n, .accept,
		.func, .opcode, .fin_flag, .payload_length,
		.mask_enable, .mask_key, .out_room, .data_byte,
		.cmd
	);

	wsfe_queue #(.Depth(QUEUE_DEPTH)) u_queue (
		.clk, .arst_n,
		.push(accept), .push_cmd(cmd), .full,
		.pop, .head_valid, .head_cmd
	);

	wsfe_back u_back (
		.clk, .arst_n, .head_valid, .head_cmd, .pop,
		.out_valid, .out_stall,
		.out_byte, .byte_valid, .status, .last, .frame_done
	);

endmodule
`default_nettype wire

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for websocket_frame_encoder_unit: a directed table of
// rejects, header length forms and frame abandonment, then random frames and
// noise, with every result checked against the table's expected status or a cycle-free frame predictor.
// ----------------------------------------------------------------------------
module testbench import wsfe_pkg::*; ();

	localparam int ITEM_COUNT  = 460;
	localparam int CALM_TAIL   = 60;
	localparam int REPORT_MAX  = 10;
	localparam int STUCK_LIMIT = 1000;
	localparam int ROW_MAX     = 32;

	localparam logic [63:0] ALL_ONES = '1;

	localparam logic [3:0] OPC_CONT     = 4'd0;
	localparam logic [3:0] OPC_TEXT     = 4'd1;
	localparam logic [3:0] OPC_BINARY   = 4'd2;
	localparam logic [3:0] OPC_RSV_DATA = 4'd3;
	localparam logic [3:0] OPC_PING     = 4'd9;
	localparam logic [3:0] OPC_RSV_TOP  = 4'd15;

	typedef struct packed {
		logic        func;
		logic [3:0]  opc;
		logic        fin;
		logic [63:0] len;
		logic        mask;
		logic [31:0] key;
		logic [63:0] cap;
		logic [7:0]  data;
	} frame_req_t;

	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic [1:0] status;
		logic       last;
		logic       done;
	} enc_byte_t;

	typedef struct {
		frame_req_t req;
		bit         fixed;
		logic [1:0] err;
	} directed_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        func;
	logic [3:0]  opcode;
	logic        fin_flag;
	logic [63:0] payload_length;
	logic        mask_enable;
	logic [31:0] mask_key;
	logic [63:0] out_room;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  out_byte;
	logic        byte_valid;
	logic [1:0]  status;
	logic        last;
	logic        frame_done;

	// predictor state
	logic        open_frame;
	logic [63:0] bytes_left;
	logic [31:0] frame_key;
	logic        frame_masked;
	logic [1:0]  key_idx;

	// oldest expected item sits at the back
	enc_byte_t     expected_bytes[$];
	enc_byte_t     step_bytes[14];
	int            step_count;
	directed_row_t directed_rows[ROW_MAX];
	int            row_count;
	logic [3:0]    good_ops[6] = '{OPC_CONT, OPC_TEXT, OPC_BINARY, OPC_CLOSE, OPC_PING, OPC_PONG};

	int idle_pct;
	int items_sent;
	int mismatches;
	int stuck_cycles;

	websocket_frame_encoder_unit u_dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] header_size(input logic [63:0] n, input logic m);
		header_size = 64'd2 + (m ? 64'd4 : 64'd0);
		if (n > 64'hFFFF)
			header_size += 64'd8;
		else if (n >= LEN_CODE_16)
			header_size += 64'd2;
	endfunction

	function automatic logic [7:0] key_lane(input logic [31:0] k, input logic [1:0] i);
		return k[8 * (3 - i) +: 8];
	endfunction

	function automatic enc_byte_t make_out(input logic [7:0] d, input logic v,
			input logic [1:0] st, input logic l, input logic dn);
		enc_byte_t e;
		e.data   = d;
		e.valid  = v;
		e.status = st;
		e.last   = l;
		e.done   = dn;
		return e;
	endfunction

	function automatic frame_req_t start_req(input logic [3:0] opc, input logic fin,
			input logic [63:0] len, input logic mask, input logic [31:0] key,
			input logic [63:0] cap);
		frame_req_t r;
		r.func = FUNC_START;
		r.opc  = opc;
		r.fin  = fin;
		r.len  = len;
		r.mask = mask;
		r.key  = key;
		r.cap  = cap;
		r.data = 8'h00;
		return r;
	endfunction

	function automatic frame_req_t byte_req(input logic [7:0] d);
		frame_req_t r;
		r      = '0;
		r.func = FUNC_PAYLOAD;
		r.data = d;
		return r;
	endfunction

	function automatic frame_req_t random_req();
		frame_req_t r;
		r.func = 1'($urandom_range(0, 1));
		r.opc  = 4'($urandom_range(0, 15));
		r.fin  = 1'($urandom_range(0, 1));
		r.len  = {$urandom, $urandom};
		r.mask = 1'($urandom_range(0, 1));
		r.key  = $urandom;
		r.cap  = {$urandom, $urandom};
		r.data = 8'($urandom_range(0, 255));
		return r;
	endfunction

	function automatic void add_row(input frame_req_t r, input bit fixed, input logic [1:0] err);
		directed_row_t row;
		row.req   = r;
		row.fixed = fixed;
		row.err   = err;
		directed_rows[row_count] = row;
		row_count++;
	endfunction

	// Expected result bytes of one accepted item, left in step_bytes.
	task automatic encode_item(input frame_req_t r);
		logic [63:0] hdr;
		logic        ctrl;
		logic        op_ok;
		logic [7:0]  b;
		logic [7:0]  hb[14];
		int          nb;
		nb         = 0;
		step_count = 0;
		if (r.func == FUNC_PAYLOAD) begin
			if (!open_frame) begin
				step_bytes[0] = make_out(8'h00, 1'b0, ST_NO_FRAME, 1'b1, 1'b0);
				step_count    = 1;
			end else begin
				b = r.data;
				if (frame_masked)
					b ^= key_lane(frame_key, key_idx);
				key_idx    += 2'd1;
				bytes_left -= 64'd1;
				open_frame  = (bytes_left != 0);
				step_bytes[0] = make_out(b, 1'b1, ST_OK, 1'b1, bytes_left == 0);
				step_count    = 1;
			end
		end else begin
			// a new start always drops whatever frame was open
			open_frame = 1'b0;
			bytes_left = '0;
			ctrl  = (r.opc >= OPC_CLOSE) && (r.opc <= OPC_PONG);
			op_ok = (r.opc <= OPC_DATA_MAX) || ctrl;
			hdr   = header_size(r.len, r.mask);
			if (!op_ok || (ctrl && (!r.fin || r.len > LEN_CTRL_MAX))) begin
				step_bytes[0] = make_out(8'h00, 1'b0, ST_INVALID, 1'b1, 1'b0);
				step_count    = 1;
			end else if (r.len > ALL_ONES - hdr || r.cap < r.len + hdr) begin
				step_bytes[0] = make_out(8'h00, 1'b0, ST_NO_SPACE, 1'b1, 1'b0);
				step_count    = 1;
			end else begin
				hb[nb] = {r.fin, 3'b000, r.opc};
				nb++;
				if (r.len < LEN_CODE_16) begin
					hb[nb] = {r.mask, r.len[6:0]};
					nb++;
				end else if (r.len <= 64'hFFFF) begin
					hb[nb] = {r.mask, LEN_CODE_16};
					hb[nb + 1] = r.len[15:8];
					hb[nb + 2] = r.len[7:0];
					nb += 3;
				end else begin
					hb[nb] = {r.mask, LEN_CODE_64};
					nb++;
					for (int i = 7; i >= 0; i--) begin
						hb[nb] = r.len[8 * i +: 8];
						nb++;
					end
				end
				if (r.mask)
					for (int i = 0; i < 4; i++) begin
						hb[nb] = key_lane(r.key, 2'(i));
						nb++;
					end
				for (int i = 0; i < nb; i++)
					step_bytes[i] = make_out(hb[i], 1'b1, ST_OK, i == nb - 1,
						(i == nb - 1) && (r.len == 0));
				step_count   = nb;
				open_frame   = (r.len != 0);
				bytes_left   = r.len;
				frame_key    = r.key;
				frame_masked = r.mask;
				key_idx      = 2'd0;
			end
		end
	endtask

	task automatic send_item(input frame_req_t r, input bit fixed, input logic [1:0] err);
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		func           <= r.func;
		opcode         <= r.opc;
		fin_flag       <= r.fin;
		payload_length <= r.len;
		mask_enable    <= r.mask;
		mask_key       <= r.key;
		out_room       <= r.cap;
		data_byte      <= r.data;
		in_valid       <= 1'b1;
		do @(posedge clk); while (in_stall);
		encode_item(r);
		if (fixed)
			expected_bytes.push_front(make_out(8'h00, 1'b0, err, 1'b1, 1'b0));
		else
			for (int i = 0; i < step_count; i++)
				expected_bytes.push_front(step_bytes[i]);
		items_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
	endtask

	task automatic random_sequence();
		frame_req_t  r;
		logic [63:0] need;
		int          kind;
		int          sel;
		int          nbytes;
		kind = $urandom_range(0, 99);
		r    = random_req();
		if (kind < 70) begin
			r.func = FUNC_START;
			r.opc  = good_ops[$urandom_range(0, 5)];
			sel    = $urandom_range(0, 9);
			if (r.opc >= OPC_CLOSE) begin
				r.fin = 1'b1;
				r.len = (sel == 0) ? 64'($urandom_range(13, 125)) : 64'($urandom_range(0, 12));
			end else if (sel == 0) begin
				r.len = 64'($urandom_range(126, 65535));
			end else if (sel == 1) begin
				r.len     = {$urandom, $urandom} >> $urandom_range(0, 47);
				r.len[16] = 1'b1;
				if (r.len > ALL_ONES - 64'd14)
					r.len = ALL_ONES - 64'd14;
			end else begin
				r.len = 64'($urandom_range(0, 12));
			end
			need = r.len + header_size(r.len, r.mask);
			sel  = $urandom_range(0, 9);
			if (sel == 0)
				r.cap = need - 64'd1;
			else if (sel < 4 || need > ALL_ONES - 64'd16)
				r.cap = ALL_ONES;
			else
				r.cap = need + 64'($urandom_range(0, 15));
			nbytes = (r.len <= 64'd12) ? int'(r.len) : $urandom_range(0, 6);
			if (r.len <= 64'd12 && $urandom_range(0, 9) == 0)
				nbytes = $urandom_range(0, nbytes + 1);
			send_item(r, 1'b0, ST_OK);
			repeat (nbytes) begin
				r      = random_req();
				r.func = FUNC_PAYLOAD;
				send_item(r, 1'b0, ST_OK);
			end
		end else if (kind < 85) begin
			r.func = FUNC_START;
			if ($urandom_range(0, 1)) begin
				r.len = 64'($urandom_range(0, 200));
				r.cap = 64'($urandom_range(0, 220));
			end
			send_item(r, 1'b0, ST_OK);
		end else begin
			r.func = FUNC_PAYLOAD;
			send_item(r, 1'b0, ST_OK);
		end
	endtask

	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 3) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : result_check
		enc_byte_t got;
		enc_byte_t want;
		got = make_out(out_byte, byte_valid, status, last, frame_done);
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("websocket_frame_encoder_unit test failed");
			$finish;
		end else if (arst_n && out_valid && !out_stall) begin
			if (expected_bytes.size() == 0) begin
				if (mismatches < REPORT_MAX)
					$display("unexpected item: byte %02h valid %b status %0d last %b done %b",
						got.data, got.valid, got.status, got.last, got.done);
				mismatches++;
			end else begin
				want = expected_bytes.pop_back();
				if (got.data !== want.data || got.valid !== want.valid ||
						got.status !== want.status || got.last !== want.last ||
						got.done !== want.done) begin
					if (mismatches < REPORT_MAX)
						$display("mismatch: exp %02h/%b/%0d/%b/%b got %02h/%b/%0d/%b/%b",
							want.data, want.valid, want.status, want.last, want.done,
							got.data, got.valid, got.status, got.last, got.done);
					mismatches++;
				end
			end
		end
	end

	initial begin
		arst_n         <= 1'b0;
		in_valid       <= 1'b0;
		func           <= FUNC_START;
		opcode         <= OPC_CONT;
		fin_flag       <= 1'b0;
		payload_length <= '0;
		mask_enable    <= 1'b0;
		mask_key       <= '0;
		out_room       <= '0;
		data_byte      <= '0;
		open_frame     = 1'b0;
		bytes_left     = '0;
		frame_key      = '0;
		frame_masked   = 1'b0;
		key_idx        = 2'd0;
		idle_pct       = 15;
		items_sent     = 0;
		mismatches     = 0;
		stuck_cycles   = 0;
		row_count      = 0;
		step_count     = 0;

		add_row(byte_req(8'h5A), 1'b1, ST_NO_FRAME);
		add_row(start_req(OPC_RSV_DATA, 1'b1, 64'd5, 1'b0, 32'h0, ALL_ONES), 1'b1, ST_INVALID);
		add_row(start_req(OPC_RSV_TOP, 1'b1, 64'd0, 1'b1, 32'hFFFF_FFFF, ALL_ONES),
			1'b1, ST_INVALID);
		add_row(start_req(OPC_CLOSE, 1'b0, 64'd0, 1'b0, 32'h0, ALL_ONES), 1'b1, ST_INVALID);
		add_row(start_req(OPC_PING, 1'b1, 64'd126, 1'b0, 32'h0, ALL_ONES), 1'b1, ST_INVALID);
		add_row(start_req(OPC_TEXT, 1'b1, 64'd10, 1'b0, 32'h0, 64'd11), 1'b1, ST_NO_SPACE);
		add_row(start_req(OPC_TEXT, 1'b1, 64'd0, 1'b0, 32'h0, 64'd0), 1'b1, ST_NO_SPACE);
		add_row(start_req(OPC_BINARY, 1'b1, ALL_ONES, 1'b0, 32'h0, ALL_ONES), 1'b1, ST_NO_SPACE);
		add_row(start_req(OPC_BINARY, 1'b0, ALL_ONES - 64'd13, 1'b1, 32'h1234_5678, ALL_ONES),
			1'b1, ST_NO_SPACE);
		// largest length that still fits, 64-bit length form with key
		add_row(start_req(OPC_CONT, 1'b0, ALL_ONES - 64'd14, 1'b1, 32'hA1B2_C3D4, ALL_ONES),
			1'b0, ST_OK);
		add_row(byte_req(8'h00), 1'b0, ST_OK);
		add_row(start_req(OPC_TEXT, 1'b1, 64'd0, 1'b0, 32'h0, 64'd2), 1'b0, ST_OK);
		add_row(byte_req(8'hFF), 1'b1, ST_NO_FRAME);
		add_row(start_req(OPC_PONG, 1'b1, 64'd125, 1'b1, 32'hFFFF_FFFF, 64'd131), 1'b0, ST_OK);
		add_row(byte_req(8'h00), 1'b0, ST_OK);
		add_row(byte_req(8'hFF), 1'b0, ST_OK);
		add_row(byte_req(8'h3C), 1'b0, ST_OK);
		// abandons the open control frame
		add_row(start_req(OPC_TEXT, 1'b1, 64'd126, 1'b1, 32'h0102_0304, 64'd134), 1'b0, ST_OK);
		add_row(byte_req(8'hFF), 1'b0, ST_OK);
		add_row(start_req(OPC_BINARY, 1'b1, 64'hFFFF, 1'b0, 32'h0, ALL_ONES), 1'b0, ST_OK);
		add_row(start_req(OPC_CONT, 1'b1, 64'h1_0000, 1'b0, 32'h0, ALL_ONES), 1'b0, ST_OK);
		add_row(start_req(OPC_CLOSE, 1'b1, 64'd3, 1'b1, 32'hDEAD_BEEF, ALL_ONES), 1'b0, ST_OK);
		add_row(byte_req(8'h11), 1'b0, ST_OK);
		add_row(byte_req(8'h22), 1'b0, ST_OK);
		add_row(byte_req(8'h33), 1'b0, ST_OK);
		add_row(byte_req(8'h44), 1'b1, ST_NO_FRAME);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < row_count; i++)
			send_item(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].err);
		drain_results();

		while (items_sent < ITEM_COUNT) begin
			if (items_sent >= ITEM_COUNT - CALM_TAIL)
				idle_pct = 0;
			else if ($urandom_range(0, 39) == 0)
				case ($urandom_range(0, 2))
					0: idle_pct = 0;
					1: idle_pct = 8;
					default: idle_pct = 25;
				endcase
			if (items_sent >= ITEM_COUNT / 2 && items_sent < ITEM_COUNT / 2 + 3)
				drain_results();
			random_sequence();
		end
		drain_results();
		repeat (32) @(posedge clk);
		@(negedge clk);

		if (mismatches == 0 && expected_bytes.size() == 0)
			$display("websocket_frame_encoder_unit test passed");
		else
			$display("websocket_frame_encoder_unit test failed");
		$finish;
	end

endmodule

[filelist.f]
src/wsfe_pkg.sv
src/wsfe_front.sv
src/wsfe_queue.sv
src/wsfe_back.sv
src/websocket_frame_encoder_unit.sv
verif/testbench.sv
